// ===== design/y10u_pkg.sv =====
// Shared types, constants and the block-slot decoder for the packed 10-bit
// luma unpacker. No dependencies; the unpacker, address stage and top level import it.
package y10u_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;

  localparam int unsigned CfgW    = 11;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned AddrW   = 20;
  localparam int unsigned PosW    = 5;
  localparam int unsigned RowW    = 10;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgW-1:0] ActiveWidthRst = 11'd640;
  localparam logic [CfgW-1:0] FrameHeightRst = 11'd480;
  localparam logic [CfgW-1:0] LineBytesRst   = 11'd832;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_WIDTH = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_LINE_BYTES   = 2'd2
  } cfg_idx_e;

  // What the current byte slot of a 32-byte block completes.
  typedef enum logic [2:0] {
    SLOT_NONE = 3'd0,
    SLOT_SH2  = 3'd1,
    SLOT_SH4  = 3'd2,
    SLOT_SH6  = 3'd3,
    SLOT_FULL = 3'd4
  } slot_e;

  typedef struct packed {
    logic [CfgW-1:0] active_width;
    logic [CfgW-1:0] frame_height;
    logic [CfgW-1:0] line_bytes;
  } cfg_t;

  // One finished pixel on its way to the address stage.
  typedef struct packed {
    logic [ByteW-1:0] value;
    logic [CfgW-1:0]  col_rev;
    logic [CfgW-1:0]  height;
    logic [RowW-1:0]  row;
    logic             last;
  } pix_t;

  // Six 5-byte groups hold a continuous 10-bit stream; slot 31 closes the
  // trailing two-byte pixel and slot 30 is its first byte.
  function automatic slot_e slot_kind(input logic [PosW-1:0] pos);
    slot_e kind;
    unique case (pos)
      5'd1, 5'd6, 5'd11, 5'd16, 5'd21, 5'd26, 5'd31: kind = SLOT_SH2;
      5'd2, 5'd7, 5'd12, 5'd17, 5'd22, 5'd27:        kind = SLOT_SH4;
      5'd3, 5'd8, 5'd13, 5'd18, 5'd23, 5'd28:        kind = SLOT_SH6;
      5'd4, 5'd9, 5'd14, 5'd19, 5'd24, 5'd29:        kind = SLOT_FULL;
      default:                                       kind = SLOT_NONE;
    endcase
    return kind;
  endfunction

endpackage

// ===== design/y10u_unpack.sv =====
// Byte parser and line/frame counters of the unpacker; registers each
// finished pixel with its reversed column, stride and row. Uses y10u_pkg.
module y10u_unpack #(
  parameter int unsigned MAX_WIDTH  = y10u_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = y10u_pkg::MaxHeightDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  y10u_pkg::cfg_t        cfg_i,
  input  logic                  accept_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  take_i,
  output logic                  pix_valid_o,
  output y10u_pkg::pix_t        pix_o
);
  import y10u_pkg::*;

  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
  localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);

  logic [ByteW-1:0] held_q, held_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [CfgW-1:0]  col_q, col_d;
  logic [CfgW-1:0]  lbc_q, lbc_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             pix_valid_q, pix_valid_d;
  pix_t             pix_q;

  logic [CfgW-1:0]  eff_w, eff_h;
  slot_e            kind;
  logic [ByteW-1:0] value;
  logic             have, emit, last;
  logic [CfgW-1:0]  lbc_inc;
  logic [CfgW-1:0]  row_inc;
  logic             line_end;

  assign eff_w = ({2'b00, cfg_i.active_width} < MaxW) ? cfg_i.active_width : MaxW[CfgW-1:0];
  assign eff_h = ({2'b00, cfg_i.frame_height} < MaxH) ? cfg_i.frame_height : MaxH[CfgW-1:0];

  assign kind = slot_kind(pos_q);
  assign have = (kind != SLOT_NONE);

  always_comb begin
    unique case (kind)
      SLOT_SH2:  value = {data_byte_i[1:0], held_q[7:2]};
      SLOT_SH4:  value = {data_byte_i[3:0], held_q[7:4]};
      SLOT_SH6:  value = {data_byte_i[5:0], held_q[7:6]};
      SLOT_FULL: value = data_byte_i;
      default:   value = '0;
    endcase
  end

  assign row_inc = {1'b0, row_q} + 11'd1;
  assign emit    = have && (col_q < eff_w);
  assign last    = (({1'b0, col_q} + 12'd1) == {1'b0, eff_w}) && (eff_h != '0) &&
                   (row_inc == eff_h);

  assign lbc_inc  = lbc_q + 11'd1;
  assign line_end = (lbc_inc >= cfg_i.line_bytes) || (lbc_inc == '0);

  always_comb begin
    held_d = held_q;
    pos_d  = pos_q;
    col_d  = col_q;
    lbc_d  = lbc_q;
    row_d  = row_q;
    if (accept_i) begin
      held_d = data_byte_i;
      pos_d  = pos_q + 5'd1;
      col_d  = have ? col_q + 11'd1 : col_q;
      lbc_d  = lbc_inc;
      if (line_end) begin
        pos_d = '0;
        col_d = '0;
        lbc_d = '0;
        row_d = (row_inc >= eff_h) ? '0 : row_inc[RowW-1:0];
      end
    end
  end

  always_comb begin
    pix_valid_d = pix_valid_q;
    if (accept_i) begin
      pix_valid_d = emit;
    end else if (take_i) begin
      pix_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      pos_q       <= '0;
      col_q       <= '0;
      lbc_q       <= '0;
      row_q       <= '0;
      pix_valid_q <= 1'b0;
    end else begin
      held_q      <= held_d;
      pos_q       <= pos_d;
      col_q       <= col_d;
      lbc_q       <= lbc_d;
      row_q       <= row_d;
      pix_valid_q <= pix_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && emit) begin
      pix_q.value   <= value;
      pix_q.col_rev <= eff_w - 11'd1 - col_q;
      pix_q.height  <= eff_h;
      pix_q.row     <= row_q;
      pix_q.last    <= last;
    end
  end

  assign pix_valid_o = pix_valid_q;
  assign pix_o       = pix_q;

endmodule

// ===== design/y10u_addr.sv =====
// Output stage of the unpacker: forms the rotated address with one
// multiply-add and holds the result until it is taken. Uses y10u_pkg.
module y10u_addr (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pix_valid_i,
  input  y10u_pkg::pix_t        pix_i,
  output logic                  take_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            pixel_value_o,
  output logic [19:0]           out_address_o,
  output logic                  frame_last_o
);
  import y10u_pkg::*;

  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] value_q;
  logic [AddrW-1:0] addr_q;
  logic             last_q;
  logic [2*CfgW-1:0] product;
  logic [2*CfgW-1:0] addr_full;

  // The register is free when empty or when its request leaves this cycle.
  assign take_o = !out_valid_q || !out_stall_i;

  assign product   = pix_i.col_rev * pix_i.height;
  assign addr_full = product + {12'd0, pix_i.row};

  assign out_valid_d = take_o ? pix_valid_i : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && pix_valid_i) begin
      value_q <= pix_i.value;
      addr_q  <= addr_full[AddrW-1:0];
      last_q  <= pix_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = value_q;
  assign out_address_o = addr_q;
  assign frame_last_o  = last_q;

endmodule

// ===== design/packed_y10_unpack_rotate.sv =====
// Top level of the packed 10-bit luma unpacker with 90-degree rotation.
// Instantiates y10u_unpack and y10u_addr; types come from y10u_pkg.
//
// Usage: one byte of the packed stream is offered per request on the input
// channel (in_valid_i, data_byte_i, in_stall_o). Each 32-byte block carries
// 25 pixels. For every finished pixel inside the active width, one request
// leaves on the output channel (out_valid_o, pixel_value_o, out_address_o,
// frame_last_o, out_stall_i) carrying the pixel's upper eight bits, its
// address in the counter-clockwise rotated frame, and a flag on the last
// pixel of the frame. Bytes that complete no pixel, and bytes past the
// active width, produce nothing.
// Throughput is one byte per cycle with no bubbles while in_stall_o is low. A
// pixel reaches the output ports through the parser register, which the edge
// that accepts its closing byte loads, and then the multiply-add register.
// When the receiver stalls, the output request holds steady; the parser
// keeps taking bytes until its register holds one more pixel, after which
// in_stall_o rises until the output moves again.
// Reset clears all counters, loads width 640, height 480 and line length 832,
// and empties both stages. Configuration writes (cfg_valid_i, cfg_ready_o,
// cfg_index_i, cfg_data_i) are always taken and belong in idle periods.
module packed_y10_unpack_rotate #(
  parameter int unsigned MAX_WIDTH  = y10u_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = y10u_pkg::MaxHeightDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [y10u_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [y10u_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     pixel_value_o,
  output logic [19:0]                    out_address_o,
  output logic                           frame_last_o
);
  import y10u_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic accept;
  logic take;
  logic pix_valid;
  pix_t pix;

  // Configuration registers; an index beyond the list is accepted and ignored.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ACTIVE_WIDTH: cfg_d.active_width = cfg_data_i;
        CFG_FRAME_HEIGHT: cfg_d.frame_height = cfg_data_i;
        CFG_LINE_BYTES:   cfg_d.line_bytes   = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_width <= ActiveWidthRst;
      cfg_q.frame_height <= FrameHeightRst;
      cfg_q.line_bytes   <= LineBytesRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The input stalls only when the parser register is full and the output
  // register cannot take its pixel this cycle.
  assign in_stall_o = pix_valid && !take;
  assign accept     = in_valid_i && !in_stall_o;

  y10u_unpack #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .take_i      (take),
    .pix_valid_o (pix_valid),
    .pix_o       (pix)
  );

  y10u_addr u_addr (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_valid_i   (pix_valid),
    .pix_i         (pix),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_value_o (pixel_value_o),
    .out_address_o (out_address_o),
    .frame_last_o  (frame_last_o)
  );

endmodule

// ===== design/y10u_chk.sv =====
// Port-level checker for packed_y10_unpack_rotate, attached by the bind
// statement at the end of this file. Uses only the top level's ports.
module y10u_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  pixel_value_o,
  input logic [19:0] out_address_o,
  input logic        frame_last_o
);

  // A stalled output request keeps its valid and payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_value_o) &&
      $stable(out_address_o) && $stable(frame_last_o))
    else $error("stalled output request changed");

  // The input is held back only while the output is blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked output");

  // A fresh output request follows an accepted byte that loaded the parser register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("output request without an accepted byte");

  // The frame's last pixel sits in rotated row zero, so its address is its input row.
  a_last_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> out_address_o < 20'd2048)
    else $error("last pixel address outside the first rotated row");

endmodule

bind packed_y10_unpack_rotate y10u_chk u_chk (.*);
